>>> rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file lud_checker.sv
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lud_pkg.sv
// -----------------------------------------------------------------------------
// lud_pkg
// types and decode helpers for the lenient utf-8 decoder
// -----------------------------------------------------------------------------
package lud_pkg;

    localparam int unsigned MaxResults = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_length;
        logic        last_of_run;
    } t_out_item;

    // results caused by one request, item[0] goes out first
    typedef struct packed {
        logic [1:0]                      count;
        t_out_item [MaxResults-1:0]      item;
    } t_run;

    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  used;
    } t_dec;

    localparam logic [7:0] MaskTop1   = 8'h80;
    localparam logic [7:0] MaskTop3   = 8'hE0;
    localparam logic [7:0] LeadTwo    = 8'hC0;
    localparam logic [7:0] MaskTop4   = 8'hF0;
    localparam logic [7:0] LeadThree  = 8'hE0;
    localparam logic [7:0] MaskTop5   = 8'hF8;
    localparam logic [7:0] LeadFour   = 8'hF0;

    // sequence length asked for by a lead byte, 0 for an invalid lead
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if ((c & MaskTop1) == 8'h00) begin
            len = 3'd1;
        end else if ((c & MaskTop3) == LeadTwo) begin
            len = 3'd2;
        end else if ((c & MaskTop4) == LeadThree) begin
            len = 3'd3;
        end else if ((c & MaskTop5) == LeadFour) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // decode one item at position p of a buffer holding n bytes
    function automatic t_dec decode_at(input logic [3:0][7:0] b,
                                       input logic [1:0] p,
                                       input logic [2:0] n);
        t_dec       d;
        logic [7:0] c;
        logic [2:0] need;
        logic [2:0] reach;
        logic [1:0] p1;
        logic [1:0] p2;
        logic [1:0] p3;
        c     = b[p];
        need  = lead_length(c);
        reach = {1'b0, p} + need;
        p1    = p + 2'd1;
        p2    = p + 2'd2;
        p3    = p + 2'd3;
        if (need <= 3'd1 || reach > n) begin
            d.cp   = {13'd0, c};
            d.used = 3'd1;
        end else if (need == 3'd2) begin
            d.cp   = {10'd0, c[4:0], b[p1][5:0]};
            d.used = 3'd2;
        end else if (need == 3'd3) begin
            d.cp   = {5'd0, c[3:0], b[p1][5:0], b[p2][5:0]};
            d.used = 3'd3;
        end else begin
            d.cp   = {c[2:0], b[p1][5:0], b[p2][5:0], b[p3][5:0]};
            d.used = 3'd4;
        end
        return d;
    endfunction

endpackage

>>> rtl/core/lud_decode.sv
// -----------------------------------------------------------------------------
// lud_decode
// open-sequence state and single-pass decode of the registered request
// -----------------------------------------------------------------------------
module lud_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  lud_pkg::t_in_item i_item,
    output lud_pkg::t_run     o_run
);

    logic [7:0] r_held [3];
    logic [1:0] r_held_cnt;
    logic [2:0] r_seq_len;
    logic [1:0] n_held_cnt;
    logic [2:0] n_seq_len;

    logic [3:0][7:0] buf_bytes;
    logic [2:0]      buf_len;
    logic [2:0]      need_c;
    logic            hold;
    lud_pkg::t_dec   d0;
    lud_pkg::t_dec   d1;
    lud_pkg::t_dec   d2;
    logic [2:0]      pos1;
    logic [2:0]      pos2;
    logic            has1;
    logic            has2;

    // held bytes first, the new byte right after them
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i < 3 && 2'(i) < r_held_cnt) begin
                buf_bytes[i] = r_held[i < 3 ? i : 0];
            end else if (3'(i) == {1'b0, r_held_cnt}) begin
                buf_bytes[i] = i_item.data_byte;
            end else begin
                buf_bytes[i] = 8'h00;
            end
        end
    end

    assign buf_len = {1'b0, r_held_cnt} + 3'd1;
    assign need_c  = lud_pkg::lead_length(i_item.data_byte);

    always_comb begin
        if (r_seq_len == 3'd0) begin
            hold = (need_c >= 3'd2) && !i_item.end_of_buffer;
        end else begin
            hold = (buf_len < r_seq_len) && !i_item.end_of_buffer;
        end
    end

    // up to three chained decodes, later ones only on a truncated sequence
    assign d0   = lud_pkg::decode_at(buf_bytes, 2'd0, buf_len);
    assign pos1 = d0.used;
    assign has1 = pos1 < buf_len;
    assign d1   = lud_pkg::decode_at(buf_bytes, pos1[1:0], buf_len);
    assign pos2 = pos1 + d1.used;
    assign has2 = has1 && (pos2 < buf_len);
    assign d2   = lud_pkg::decode_at(buf_bytes, pos2[1:0], buf_len);

    always_comb begin
        o_run.item[0].code_point  = d0.cp;
        o_run.item[0].byte_length = d0.used;
        o_run.item[0].last_of_run = !has1;
        o_run.item[1].code_point  = d1.cp;
        o_run.item[1].byte_length = d1.used;
        o_run.item[1].last_of_run = !has2;
        o_run.item[2].code_point  = d2.cp;
        o_run.item[2].byte_length = d2.used;
        o_run.item[2].last_of_run = 1'b1;
        if (hold) begin
            o_run.count = 2'd0;
        end else begin
            o_run.count = 2'd1 + 2'(has1) + 2'(has2);
        end
    end

    always_comb begin
        if (hold) begin
            if (r_seq_len == 3'd0) begin
                n_held_cnt = 2'd1;
                n_seq_len  = need_c;
            end else begin
                n_held_cnt = r_held_cnt + 2'd1;
                n_seq_len  = r_seq_len;
            end
        end else begin
            n_held_cnt = 2'd0;
            n_seq_len  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_seq_len  <= 3'd0;
        end else if (i_advance) begin
            r_held_cnt <= n_held_cnt;
            r_seq_len  <= n_seq_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && hold) begin
            r_held[r_held_cnt] <= i_item.data_byte;
        end
    end

endmodule

>>> rtl/core/lud_outbuf.sv
// -----------------------------------------------------------------------------
// lud_outbuf
// result register holding up to three results, drained one per cycle while the receiver is ready
// -----------------------------------------------------------------------------
module lud_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  lud_pkg::t_run      i_run,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output lud_pkg::t_out_item o_data
);

    lud_pkg::t_out_item r_slot [lud_pkg::MaxResults];
    logic [1:0]         r_left;
    logic               take;

    assign o_valid = r_left != 2'd0;
    assign o_data  = r_slot[0];
    assign take    = o_valid && i_ready;
    // empty now, or last result leaves this cycle
    assign o_free  = (r_left == 2'd0) || (r_left == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_run.count;
        end else if (take) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < lud_pkg::MaxResults; i++) begin
                r_slot[i] <= i_run.item[i];
            end
        end else if (take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

>>> rtl/core/lenient_utf8_decoder_core.sv
// -----------------------------------------------------------------------------
// lenient_utf8_decoder_core
// byte-stream utf-8 decoder, lenient on continuation bytes and overlong forms
// -----------------------------------------------------------------------------
// Input channel takes one byte per request with an end-of-buffer flag; output
// channel gives code points with their byte length and a flag on the last
// result a byte caused. Each byte gives zero to three results.
// A request sits in the input register, is decoded in one pass and lands in
// the result register once that register is free; the result register drives
// the output port directly.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver is ready; a byte with k results holds the result register
// until all k have left, as the output port moves one result per cycle.
// When the receiver stalls, results wait in the result register and one more
// byte waits in the input register, then the input ready drops.
// Synchronous reset empties both registers and closes any open sequence.
// -----------------------------------------------------------------------------
module lenient_utf8_decoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lud_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lud_pkg::t_out_item o_out_data
);

    logic              r_in_valid;
    lud_pkg::t_in_item r_in_item;
    logic              advance;
    logic              buf_free;
    lud_pkg::t_run     run;

    assign advance    = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    lud_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_run     (run)
    );

    lud_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_run   (run),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> rtl/core/lud_checker.sv
// -----------------------------------------------------------------------------
// lud_checker
// port-level checks on the decoder output, bound to the top level
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module lud_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lud_pkg::t_out_item o_out_data
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "stalled result changed")
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result valid right after reset")
    `ASSERT_CLK(a_len_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.byte_length != 3'd0) && (o_out_data.byte_length <= 3'd4), "byte length out of range")
    `ASSERT_CLK(a_raw_narrow, i_clk, i_rst_n, o_out_valid && o_out_data.byte_length == 3'd1 |-> o_out_data.code_point[20:8] == 13'd0, "single byte result wider than a byte")

endmodule

bind lenient_utf8_decoder_core lud_checker u_lud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> test/lud_stream_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lud_stream_checker
// watches both channels of the utf-8 decoder and checks every result
// -----------------------------------------------------------------------------
// Each accepted request is run through a local decoder that tracks the open
// sequence; the code points it gives are queued in order. Each accepted result
// is compared field by field with the head of that queue.
// -----------------------------------------------------------------------------
module lud_stream_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  lud_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  lud_pkg::t_out_item i_out_data,
    output int                 o_pending,
    output int                 o_fail_count
);

    logic [7:0]         open_bytes [3];
    logic [1:0]         open_count;
    logic [2:0]         open_length;
    lud_pkg::t_out_item code_point_q [$];
    int                 fail_count;

    assign o_pending    = code_point_q.size();
    assign o_fail_count = fail_count;

    initial fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    function automatic int lead_bytes(input logic [7:0] c);
        int len;
        casez (c)
            8'b0???????: len = 1;
            8'b110?????: len = 2;
            8'b1110????: len = 3;
            8'b11110???: len = 4;
            default:     len = 0;
        endcase
        return len;
    endfunction

    task automatic close_sequence();
        open_bytes  = '{default: 8'h00};
        open_count  = 2'd0;
        open_length = 3'd0;
    endtask

    // decodes one request and queues the code points it completes
    task automatic decode_request(input lud_pkg::t_in_item req);
        logic [7:0]         window [4];
        logic [20:0]        cp;
        lud_pkg::t_out_item found [3];
        int                 n;
        int                 p;
        int                 need;
        int                 k;
        window = '{default: 8'h00};
        if (open_length == 3'd0) begin
            need = lead_bytes(req.data_byte);
            if (need >= 2 && !req.end_of_buffer) begin
                open_bytes[0] = req.data_byte;
                open_count    = 2'd1;
                open_length   = 3'(need);
                return;
            end
            window[0] = req.data_byte;
            n = 1;
        end else begin
            for (int i = 0; i < int'(open_count); i++) window[i] = open_bytes[i];
            window[open_count] = req.data_byte;
            n = int'(open_count) + 1;
            if (n < int'(open_length) && !req.end_of_buffer) begin
                open_bytes[open_count] = req.data_byte;
                open_count++;
                return;
            end
        end
        // on a truncated buffer the lead goes out raw and the rest is rescanned
        p = 0;
        k = 0;
        while (p < n && k < 3) begin
            need = lead_bytes(window[p]);
            if (need <= 1 || p + need > n) begin
                cp   = {13'd0, window[p]};
                need = 1;
            end else begin
                case (need)
                    2:       cp = {16'd0, window[p][4:0]};
                    3:       cp = {17'd0, window[p][3:0]};
                    default: cp = {18'd0, window[p][2:0]};
                endcase
                for (int i = 1; i < need; i++) cp = (cp << 6) | {15'd0, window[p+i][5:0]};
            end
            found[k].code_point  = cp;
            found[k].byte_length = 3'(need);
            found[k].last_of_run = 1'b0;
            p += need;
            k++;
        end
        found[k-1].last_of_run = 1'b1;
        for (int i = 0; i < k; i++) code_point_q.push_back(found[i]);
        close_sequence();
    endtask

    task automatic check_result(input lud_pkg::t_out_item got);
        lud_pkg::t_out_item want;
        if (code_point_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result cp=%h", got.code_point));
            return;
        end
        want = code_point_q.pop_front();
        if (got.code_point !== want.code_point)
            report_mismatch($sformatf("code_point %h, expected %h",
                                      got.code_point, want.code_point));
        if (got.byte_length !== want.byte_length)
            report_mismatch($sformatf("byte_length %0d, expected %0d (cp %h)",
                                      got.byte_length, want.byte_length, want.code_point));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b (cp %h)",
                                      got.last_of_run, want.last_of_run, want.code_point));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            close_sequence();
            code_point_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) decode_request(i_in_data);
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the lenient utf-8 decoder
// -----------------------------------------------------------------------------
// A directed pass covers ascii, all sequence lengths, overlong and invalid
// leads, the widest code point and truncated buffers. A random pass then sends
// mostly well-formed sequences with random payload, plus truncated runs and
// noise, with random idling on both sides, one long output stall and one drain
// pause. Checking is done by lud_stream_checker.
// -----------------------------------------------------------------------------
module tb_top;

    localparam int TotalItems = 410;
    localparam int HoldCycles = 200;
    localparam int StuckLimit = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    lud_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    lud_pkg::t_out_item o_out_data;

    int   pending;
    int   fail_count;
    int   items_sent;
    logic idle_on;
    logic hold_req;

    lenient_utf8_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    lud_stream_checker u_stream_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: random stalls, ready stretches, and one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // watchdog on cycles with no request or result moving
    initial begin
        int stuck;
        stuck = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
            if (stuck >= StuckLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        lud_pkg::t_in_item req;
        int                gap;
        req.data_byte     = b;
        req.end_of_buffer = eob;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_lead(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       r = {1'b0, r[6:0]};
            2:       r = {3'b110, r[4:0]};
            3:       r = {4'b1110, r[3:0]};
            default: r = {5'b11110, r[2:0]};
        endcase
        return r;
    endfunction

    // continuation byte, now and then an arbitrary byte that may look like a lead
    function automatic logic [7:0] random_tail();
        logic [7:0] r;
        r = 8'($urandom);
        if ($urandom_range(0, 6) != 0) r = {2'b10, r[5:0]};
        return r;
    endfunction

    task automatic send_random_run();
        int kind;
        int len;
        int tail;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            len = $urandom_range(1, 4);
            if (len == 1) begin
                send_byte(random_lead(1), $urandom_range(0, 7) == 0);
            end else begin
                send_byte(random_lead(len), 1'b0);
                for (int i = 1; i < len; i++)
                    send_byte(random_tail(), i == len - 1 && $urandom_range(0, 7) == 0);
            end
        end else if (kind < 78) begin
            // buffer ends inside the sequence
            len  = $urandom_range(2, 4);
            tail = $urandom_range(0, len - 2);
            send_byte(random_lead(len), tail == 0);
            for (int i = 1; i <= tail; i++) send_byte(random_tail(), i == tail);
        end else begin
            send_byte(8'($urandom), $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        logic [8:0] directed_q [$];
        logic       hold_done;
        logic       pause_done;
        // {end_of_buffer, data_byte}
        directed_q = '{
            9'h000, 9'h17F,                 // ascii extremes
            9'h0C2, 9'h0A9,                 // two bytes
            9'h0E2, 9'h082, 9'h0AC,         // three bytes
            9'h0F0, 9'h09F, 9'h098, 9'h080, // four bytes
            9'h0C0, 9'h080,                 // overlong
            9'h080, 9'h0FF, 9'h0F8,         // stray continuation, invalid leads
            9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF, // widest code point, flag on last byte
            9'h1E0,                         // lead alone at end of buffer
            9'h0F0, 9'h041, 9'h1C3,         // truncated, lead and rest go out raw
            9'h0E1, 9'h0E2, 9'h041          // lead-like byte taken as continuation
        };
        hold_done  = 1'b0;
        pause_done = 1'b0;
        items_sent = 0;
        idle_on    = 1'b0;
        hold_req   = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i]) send_byte(directed_q[i][7:0], directed_q[i][8]);
        wait_drained();

        idle_on = 1'b1;
        while (items_sent < TotalItems) begin
            if (!hold_done && items_sent >= 150) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 260) begin
                wait_drained();
                pause_done = 1'b1;
            end
            // last stretch runs at full rate
            if (items_sent >= TotalItems - 60) idle_on = 1'b0;
            send_random_run();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lud_pkg.sv
rtl/core/lud_decode.sv
rtl/core/lud_outbuf.sv
rtl/core/lenient_utf8_decoder_core.sv
rtl/core/lud_checker.sv
test/lud_stream_checker.sv
test/tb_top.sv
